// ===== rtl/core/ash_pkg.sv =====
// Shared types and constants for the accelerometer shake detector.
// Used by ash_div and the top level under rtl/core; depends on nothing.
`default_nettype none

package ash_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  // Register indexes of the write port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RAW_GATE        = 3'd0,
    CFG_FIRE_THRESHOLD  = 3'd1,
    CFG_FULL_POWER_SPAN = 3'd2,
    CFG_SMOOTH_WEIGHT   = 3'd3,
    CFG_COOLDOWN_BASE   = 3'd4,
    CFG_REARM_COOLDOWN  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_REARM  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL,
    ST_DIV,
    ST_OUT
  } state_e;

  localparam logic [15:0] RawGateRst   = 16'd2300;
  localparam logic [15:0] ThresholdRst = 16'd3600;
  localparam logic [15:0] SpanRst      = 16'd9300;
  localparam logic [8:0]  WeightRst    = 9'd61;
  localparam logic [3:0]  CoolBaseRst  = 4'd8;
  localparam logic [3:0]  RearmRst     = 4'd8;

  localparam logic [8:0]  PowerFull    = 9'd256;
  localparam logic [23:0] LevelMax     = 24'hFF_FFFF;

  typedef struct packed {
    logic               command;
    logic signed [15:0] sample;
  } in_t;

  typedef struct packed {
    logic        fired;
    logic [8:0]  power;
    logic [15:0] level;
    logic [4:0]  cooldown_left;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/core/ash_mul.sv =====
// Bit-serial signed x unsigned multiplier, one weight bit per cycle (LSB first).
// Returns floor(diff * weight / 256). Depends on nothing but the clock and reset.
`default_nettype none

module ash_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [24:0] diff_i,
  input  wire logic [8:0]         weight_i,
  output logic                    done_o,
  output logic signed [26:0]      step_o
);

  logic signed [24:0] d_q;
  logic signed [25:0] hi_q, hi_d;
  logic [8:0]         lo_q, lo_d;
  logic [8:0]         w_q, w_d;
  logic [3:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic signed [25:0] sum;

  // partial product sits in {hi, lo}, shifted right each step
  always_comb begin
    sum    = hi_q + (w_q[0] ? 26'(d_q) : 26'sd0);
    hi_d   = hi_q;
    lo_d   = lo_q;
    w_d    = w_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      hi_d   = '0;
      lo_d   = '0;
      w_d    = weight_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = sum >>> 1;
      lo_d  = {sum[0], lo_q[8:1]};
      w_d   = w_q >> 1;
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd8) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q <= diff_i;
    end
    hi_q <= hi_d;
    lo_q <= lo_d;
    w_q  <= w_d;
  end

  // P = hi*512 + lo, so floor(P/256) = hi*2 + lo[8]
  assign step_o = {hi_q, lo_q[8]};
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== rtl/core/ash_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating at full power.
// Depends on ash_pkg for the full-power constant.
`default_nettype none

module ash_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [23:0] num_i,
  input  wire logic [15:0] den_i,
  output logic             done_o,
  output logic [8:0]       quot_o
);

  logic [15:0] den_q;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  q_q, q_d;
  logic        sat_q, sat_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [16:0] trial;
  logic        fits;

  always_comb begin
    trial  = {rem_q, low_q[7]};
    fits   = trial >= {1'b0, den_q};
    rem_d  = rem_q;
    low_d  = low_q;
    q_d    = q_q;
    sat_d  = sat_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // quotient of 256 or more (zero span included) saturates at once
      sat_d = num_i[23:8] >= den_i;
      rem_d = num_i[23:8];
      low_d = num_i[7:0];
      q_d   = '0;
      cnt_d = '0;
      if (num_i[23:8] >= den_i) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
      low_d = {low_q[6:0], 1'b0};
      q_d   = {q_q[6:0], fits};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
    end
    rem_q <= rem_d;
    low_q <= low_d;
    q_q   <= q_d;
    sat_q <= sat_d;
  end

  assign quot_o = sat_q ? ash_pkg::PowerFull : {1'b0, q_q};
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== rtl/core/accel_shake_detector_top.sv =====
// Top level of the accelerometer shake detector: control FSM, state and registers.
// Depends on ash_pkg, ash_mul and ash_div.
`default_nettype none

// One input beat gives one output beat. Items are handled one at a time: a rearm
// or priming beat goes to output, an ordinary sample passes multiply, evaluate and
// output states (the bit-serial smoothing multiply runs one weight bit per cycle),
// and a firing sample the divide state too (the power division adds one quotient
// bit per cycle). A finished result waits in the output register while the next
// beat is taken; it holds the block only if the following result is ready first.
module accel_shake_detector_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ash_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ash_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire ash_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output ash_pkg::out_t                      out_data_o
);

  // configuration
  logic [15:0] raw_gate_q, thr_q, span_q;
  logic [8:0]  weight_q;
  logic [3:0]  cool_base_q, rearm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_gate_q  <= ash_pkg::RawGateRst;
      thr_q       <= ash_pkg::ThresholdRst;
      span_q      <= ash_pkg::SpanRst;
      weight_q    <= ash_pkg::WeightRst;
      cool_base_q <= ash_pkg::CoolBaseRst;
      rearm_q     <= ash_pkg::RearmRst;
    end else if (cfg_we_i) begin
      case (ash_pkg::cfg_idx_e'(cfg_idx_i))
        ash_pkg::CFG_RAW_GATE:        raw_gate_q  <= cfg_wdata_i;
        ash_pkg::CFG_FIRE_THRESHOLD:  thr_q       <= cfg_wdata_i;
        ash_pkg::CFG_FULL_POWER_SPAN: span_q      <= cfg_wdata_i;
        ash_pkg::CFG_SMOOTH_WEIGHT:   weight_q    <= cfg_wdata_i[8:0];
        ash_pkg::CFG_COOLDOWN_BASE:   cool_base_q <= cfg_wdata_i[3:0];
        ash_pkg::CFG_REARM_COOLDOWN:  rearm_q     <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  ash_pkg::state_e state_q, state_d;
  logic [15:0] last_q, last_d;
  logic        primed_q, primed_d;
  logic [23:0] level_q, level_d;
  logic [4:0]  cool_q, cool_d;
  logic        res_fired_q, res_fired_d;
  logic [8:0]  res_power_q, res_power_d;
  ash_pkg::out_t out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic               in_acc;
  logic signed [16:0] dz;
  logic [15:0]        mag, gated;
  logic signed [24:0] diff;
  logic               mul_start, mul_done;
  logic signed [26:0] mul_step;
  logic signed [27:0] next_lvl;
  logic [23:0]        thr_ext;
  logic               div_start, div_done;
  logic [23:0]        excess;
  logic [8:0]         div_quot;
  logic [10:0]        pow3;

  ash_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .diff_i   (diff),
    .weight_i (weight_q),
    .done_o   (mul_done),
    .step_o   (mul_step)
  );

  ash_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (excess),
    .den_i   (span_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign in_stall_o = (state_q != ash_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    dz       = 17'(in_data_i.sample) - 17'($signed(last_q));
    mag      = dz[16] ? 16'(-dz) : dz[15:0];
    gated    = (mag < raw_gate_q) ? 16'd0 : mag;
    diff     = $signed({1'b0, gated, 8'h00}) - $signed({1'b0, level_q});
    next_lvl = 28'($signed({1'b0, level_q})) + 28'(mul_step);
    thr_ext  = {thr_q, 8'h00};
    excess   = level_q - thr_ext;
    pow3     = {2'b00, div_quot} + {1'b0, div_quot, 1'b0};

    state_d     = state_q;
    last_d      = last_q;
    primed_d    = primed_q;
    level_d     = level_q;
    cool_d      = cool_q;
    res_fired_d = res_fired_q;
    res_power_d = res_power_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_start   = 1'b0;
    div_start   = 1'b0;

    case (state_q)
      ash_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_fired_d = 1'b0;
          res_power_d = '0;
          if (in_data_i.command == ash_pkg::CMD_REARM) begin
            level_d  = '0;
            primed_d = 1'b0;
            cool_d   = {1'b0, rearm_q};
            state_d  = ash_pkg::ST_OUT;
          end else if (!primed_q) begin
            last_d   = in_data_i.sample;
            primed_d = 1'b1;
            state_d  = ash_pkg::ST_OUT;
          end else begin
            last_d    = in_data_i.sample;
            mul_start = 1'b1;
            state_d   = ash_pkg::ST_MUL;
          end
        end
      end
      ash_pkg::ST_MUL: begin
        if (mul_done) begin
          if (next_lvl < 0) begin
            level_d = '0;
          end else if (next_lvl > 28'($signed({1'b0, ash_pkg::LevelMax}))) begin
            level_d = ash_pkg::LevelMax;
          end else begin
            level_d = next_lvl[23:0];
          end
          state_d = ash_pkg::ST_EVAL;
        end
      end
      ash_pkg::ST_EVAL: begin
        if (cool_q != 5'd0) begin
          cool_d  = cool_q - 5'd1;
          state_d = ash_pkg::ST_OUT;
        end else if (level_q > thr_ext) begin
          div_start = 1'b1;
          state_d   = ash_pkg::ST_DIV;
        end else begin
          state_d = ash_pkg::ST_OUT;
        end
      end
      ash_pkg::ST_DIV: begin
        if (div_done) begin
          res_fired_d = 1'b1;
          res_power_d = div_quot;
          // extra cooldown is floor(3*power/256), 0..3
          cool_d      = {1'b0, cool_base_q} + {2'b00, pow3[10:8]};
          level_d     = '0;
          state_d     = ash_pkg::ST_OUT;
        end
      end
      ash_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.fired         = res_fired_q;
          out_d.power         = res_power_q;
          out_d.level         = level_q[23:8];
          out_d.cooldown_left = cool_q;
          out_valid_d         = 1'b1;
          state_d             = ash_pkg::ST_IDLE;
        end
      end
      default: state_d = ash_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ash_pkg::ST_IDLE;
      last_q      <= '0;
      primed_q    <= 1'b0;
      level_q     <= '0;
      cool_q      <= {1'b0, ash_pkg::RearmRst};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      primed_q    <= primed_d;
      level_q     <= level_d;
      cool_q      <= cool_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_fired_q <= res_fired_d;
    res_power_q <= res_power_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_fire_clears_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fired |-> out_data_o.level == 16'd0)
    else $error("fired beat with nonzero level");
  a_quiet_no_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.fired |-> out_data_o.power == 9'd0)
    else $error("power reported without a firing");
  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.power <= ash_pkg::PowerFull)
    else $error("power above full scale");
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ash_pkg::ST_MUL)
    else $error("multiplier finished outside multiply state");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ash_pkg::ST_DIV)
    else $error("divider finished outside divide state");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_accel_shake_detector_top.sv =====
// Testbench for accel_shake_detector_top: directed and random sample traffic checked
// beat by beat against an in-bench shake predictor. Depends on ash_pkg and the RTL.
module tb_accel_shake_detector_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ash_pkg::*;

  // register file image, fields in write-port index order
  typedef struct packed {
    logic [15:0] raw_gate;
    logic [15:0] fire_thr;
    logic [15:0] span;
    logic [8:0]  weight;
    logic [3:0]  cool_base;
    logic [3:0]  rearm_cool;
  } regs_t;

  localparam regs_t RegsRst = '{RawGateRst, ThresholdRst, SpanRst, WeightRst,
                                CoolBaseRst, RearmRst};
  localparam int unsigned CycleLimit = 300_000;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  in_t                 in_beat   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  out_t                out_beat;

  // predictor state
  regs_t              regs        = RegsRst;
  logic signed [15:0] prev_sample = '0;
  logic               armed       = 1'b0;
  logic [23:0]        shake_level = '0;
  logic [4:0]         cool_cnt    = {1'b0, RearmRst};

  out_t        expected_q[$];
  out_t        want;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  int unsigned gap_odds    = 4;
  int unsigned stall_odds  = 4;
  bit          idle_on     = 1'b1;

  accel_shake_detector_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // output backpressure: random stall bursts, each begun with odds of one in stall_odds
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v, got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result beat with no expected result pending");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("fired", want.fired, out_beat.fired);
        check_field("power", want.power, out_beat.power);
        check_field("level", want.level, out_beat.level);
        check_field("cooldown_left", want.cooldown_left, out_beat.cooldown_left);
      end
    end
  end

  // one beat through rearm, priming, gate, smoothing, cooldown and firing
  function automatic out_t predict_shake(input in_t beat);
    out_t        r;
    int          delta;
    int          mag;
    longint      prod;
    longint      nxt;
    logic [23:0] excess;
    int unsigned pw;
    r = '0;
    if (beat.command == CMD_REARM) begin
      shake_level = '0;
      armed       = 1'b0;
      cool_cnt    = {1'b0, regs.rearm_cool};
    end else if (!armed) begin
      prev_sample = beat.sample;
      armed       = 1'b1;
    end else begin
      delta = int'($signed(beat.sample)) - int'(prev_sample);
      mag   = (delta < 0) ? -delta : delta;
      prev_sample = beat.sample;
      if (mag < int'(regs.raw_gate)) mag = 0;
      // floor toward minus infinity is an arithmetic shift
      prod = (longint'(mag) * 256 - longint'(shake_level)) * longint'(regs.weight);
      nxt  = longint'(shake_level) + (prod >>> 8);
      if (nxt < 0) nxt = 0;
      else if (nxt > longint'(LevelMax)) nxt = longint'(LevelMax);
      shake_level = nxt[23:0];
      if (cool_cnt != 0) begin
        cool_cnt = cool_cnt - 1;
      end else if (shake_level > {regs.fire_thr, 8'h00}) begin
        excess = shake_level - {regs.fire_thr, 8'h00};
        pw = (regs.span == 0) ? PowerFull : excess / regs.span;
        if (pw > PowerFull) pw = PowerFull;
        r.fired     = 1'b1;
        r.power     = pw[8:0];
        cool_cnt    = 5'(regs.cool_base + ((3 * pw) >> 8));
        shake_level = '0;
      end
    end
    r.level         = shake_level[23:8];
    r.cooldown_left = cool_cnt;
    return r;
  endfunction

  function automatic in_t make_beat(input cmd_e cmd, input int s);
    in_t b;
    b.command = cmd;
    b.sample  = 16'(s);
    return b;
  endfunction

  function automatic regs_t rand_regs(input bit wide);
    regs_t r;
    r.cool_base  = 4'($urandom_range(0, 15));
    r.rearm_cool = 4'($urandom_range(0, 15));
    if (wide) begin
      r.raw_gate = 16'($urandom_range(0, 65535));
      r.fire_thr = 16'($urandom_range(0, 65535));
      r.span     = 16'($urandom_range(0, 65535));
      r.weight   = 9'($urandom_range(0, 511));
    end else begin
      // settings under which ordinary shakes fire now and then
      r.raw_gate = 16'($urandom_range(0, 4000));
      r.fire_thr = 16'($urandom_range(0, 12000));
      r.span     = 16'($urandom_range(0, 20000));
      r.weight   = 9'($urandom_range(1, 256));
    end
    return r;
  endfunction

  task automatic apply_regs(input regs_t r);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_RAW_GATE;
    cfg_wdata <= r.raw_gate;
    @(posedge clk_i);
    cfg_idx   <= CFG_FIRE_THRESHOLD;
    cfg_wdata <= r.fire_thr;
    @(posedge clk_i);
    cfg_idx   <= CFG_FULL_POWER_SPAN;
    cfg_wdata <= r.span;
    @(posedge clk_i);
    cfg_idx   <= CFG_SMOOTH_WEIGHT;
    cfg_wdata <= CfgDataW'(r.weight);
    @(posedge clk_i);
    cfg_idx   <= CFG_COOLDOWN_BASE;
    cfg_wdata <= CfgDataW'(r.cool_base);
    @(posedge clk_i);
    cfg_idx   <= CFG_REARM_COOLDOWN;
    cfg_wdata <= CfgDataW'(r.rearm_cool);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    regs = r;
  endtask

  task automatic send_item(input in_t beat);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(predict_shake(beat));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // segments of shaking, quiet drift and raw noise, with rearms sprinkled in
  task automatic run_traffic(input int n_items);
    in_t beat;
    int  seg_left;
    int  kind;
    int  amp;
    int  center;
    int  val;
    seg_left = 0;
    kind     = 0;
    amp      = 0;
    center   = 0;
    for (int i = 0; i < n_items; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(4, 24);
        kind     = $urandom_range(0, 9);
        amp      = $urandom_range(0, 32767);
        center   = int'($urandom_range(0, 16000)) - 8000;
        if (idle_on) begin
          gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
          stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
        end
      end
      if (kind < 5) val = center + ((i % 2) ? amp : -amp) + int'($urandom_range(0, 200)) - 100;
      else if (kind < 8) val = center + int'($urandom_range(0, 600)) - 300;
      else val = int'($urandom_range(0, 65535)) - 32768;
      if (val > 32767) val = 32767;
      if (val < -32768) val = -32768;
      beat = make_beat(($urandom_range(0, 29) == 0) ? CMD_REARM : CMD_SAMPLE, val);
      send_item(beat);
      seg_left--;
    end
  endtask

  task automatic test_default_regs();
    apply_regs(RegsRst);
    send_item(make_beat(CMD_SAMPLE, 1000));    // primes only
    send_item(make_beat(CMD_SAMPLE, 3299));    // one below the gate
    send_item(make_beat(CMD_SAMPLE, 5599));    // exactly at the gate
    send_item(make_beat(CMD_SAMPLE, -32768));
    send_item(make_beat(CMD_REARM, 32767));    // sample ignored
    send_item(make_beat(CMD_SAMPLE, 32767));
    send_item(make_beat(CMD_SAMPLE, 0));
  endtask

  task automatic test_full_power_zero_span();
    wait_drained();
    apply_regs('{16'd0, 16'd0, 16'd0, 9'd256, 4'd15, 4'd0});
    send_item(make_beat(CMD_REARM, 16'h1234));
    send_item(make_beat(CMD_SAMPLE, -32768));
    send_item(make_beat(CMD_SAMPLE, 32767));   // fires at full power, cooldown 18
    send_item(make_beat(CMD_SAMPLE, 32767));   // cooldown running
    send_item(make_beat(CMD_REARM, 0));
  endtask

  task automatic test_weight_extremes();
    wait_drained();
    apply_regs('{16'd65535, 16'd65535, 16'd1, 9'd511, 4'd0, 4'd15});
    send_item(make_beat(CMD_REARM, 0));
    send_item(make_beat(CMD_SAMPLE, -32768));
    send_item(make_beat(CMD_SAMPLE, 32767));   // overshoot saturates high
    send_item(make_beat(CMD_SAMPLE, 32767));   // overshoot saturates at zero
    wait_drained();
    apply_regs('{16'd65535, 16'd65535, 16'd1, 9'd0, 4'd0, 4'd15});
    send_item(make_beat(CMD_SAMPLE, -32768));  // zero weight holds the level
    wait_drained();
    apply_regs('{16'd0, 16'd1000, 16'd3, 9'd256, 4'd0, 4'd0});
    send_item(make_beat(CMD_REARM, 0));
    send_item(make_beat(CMD_SAMPLE, 0));
    send_item(make_beat(CMD_SAMPLE, 1000));    // level equals threshold: no fire
    send_item(make_beat(CMD_SAMPLE, -1));      // one past it
  endtask

  task automatic test_random_traffic();
    regs_t r;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       r = RegsRst;
        2:       r = rand_regs(1'b1);
        3:       r = '{16'd0, 16'd0, 16'd65535, 9'd1, 4'd0, 4'd0};
        4:       r = '{16'd65535, 16'd65535, 16'd65535, 9'd256, 4'd15, 4'd15};
        default: r = rand_regs(1'b0);
      endcase
      wait_drained();
      apply_regs(r);
      run_traffic(60);
    end
  endtask

  task automatic test_no_idle();
    wait_drained();
    idle_on    = 1'b0;
    gap_odds   = 0;
    stall_odds = 0;
    apply_regs(rand_regs(1'b0));
    run_traffic(60);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_regs();
    test_full_power_zero_span();
    test_weight_extremes();
    test_random_traffic();
    test_no_idle();
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
